/* hw/rtl/i2cseq_pkg.sv */
package i2cseq_pkg;

  // Default transmit/receive store depth
  localparam int BUF_DEPTH_DEFAULT = 16;

  // Most receive-complete results given for one read
  localparam int MAX_REPORT = 16;

  // Read bit OR-ed into the shifted slave address
  localparam logic [7:0] ADDR_READ_BIT = 8'h01;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_EVENT = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_RECEIVE = 3'd4,
    ACT_ACK     = 3'd5,
    ACT_STOP    = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    REP_NONE     = 2'd0,
    REP_SENT     = 2'd1,
    REP_RECEIVED = 2'd2
  } report_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_WADDR   = 4'd2,
    PH_DATA    = 4'd3,
    PH_RESTART = 4'd4,
    PH_RADDR   = 4'd5,
    PH_RESP    = 4'd6,
    PH_ACK     = 4'd7,
    PH_NACK    = 4'd8,
    PH_STOP    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    DIR_IDLE  = 2'd0,
    DIR_WRITE = 2'd1,
    DIR_READ  = 2'd2
  } dir_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;    // capture the input transfer
    logic rd_en;    // read the byte store
    logic rd_burst; // read address comes from the report index
    logic step;     // apply one input item
    logic bstep;    // give the next receive-complete result
    logic out_load; // load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result; // current step gives a result
    logic burst_go;   // current step opens a multi-result report
    logic burst_last; // current report result is the final one
  } dp_sts_t;

  // One result item
  typedef struct packed {
    action_t    action;
    logic [7:0] tx_byte;
    logic       ack_bit;
    report_t    report;
    logic [7:0] rx_byte;
    logic [4:0] rx_count;
    logic       busy;
    logic       last;
  } res_t;

endpackage

/* hw/rtl/i2cseq_ctrl.sv */
module i2cseq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output i2cseq_pkg::dp_cmd_t cmd,
  input  i2cseq_pkg::dp_sts_t sts
);
  import i2cseq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_BREAD,
    ST_BEXEC
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  // Output register can take a new result this cycle
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts.has_result || slot_free) begin
          cmd.step     = 1'b1;
          cmd.out_load = sts.has_result;
          state_next   = sts.burst_go ? ST_BREAD : ST_IDLE;
        end
      end
      ST_BREAD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_burst = 1'b1;
        state_next   = ST_BEXEC;
      end
      ST_BEXEC: begin
        if (slot_free) begin
          cmd.bstep    = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = sts.burst_last ? ST_IDLE : ST_BREAD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/i2cseq_dp.sv */
module i2cseq_dp #(
  parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  i2cseq_pkg::dp_cmd_t cmd,
  output i2cseq_pkg::dp_sts_t sts,
  input  logic [1:0]          in_command,
  input  logic [3:0]          in_byte_index,
  input  logic [7:0]          in_data_byte,
  input  logic                in_ack_status,
  input  logic [4:0]          in_length,
  input  logic [6:0]          in_slave_addr,
  input  logic [7:0]          in_reg_addr,
  output i2cseq_pkg::res_t    res
);
  import i2cseq_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // Captured input item
  cmd_code_t  cmd_code;
  logic [3:0] byte_index;
  logic [7:0] data_byte;
  logic       ack_status;
  logic [4:0] length;
  logic [6:0] slave_addr;
  logic [7:0] reg_addr;

  // Transaction state
  phase_t     phase;
  dir_t       direction;
  logic [4:0] count_target;
  logic [4:0] position;
  logic [7:0] shifted_address;
  logic [7:0] register_byte;
  logic       busy_flag;

  // Report burst
  logic [3:0] bidx;
  logic [4:0] blim;
  logic [4:0] bcnt;

  // Byte store
  logic [7:0] mem [BUF_DEPTH];
  logic [4:0] rd_addr;
  logic [7:0] rd_data;
  logic       rd_ok;
  logic [7:0] store_val;
  logic       wr_en;
  logic [4:0] wr_addr;
  logic [7:0] wr_data;

  // Step results
  phase_t     phase_next;
  dir_t       direction_next;
  logic [4:0] count_target_next;
  logic [4:0] position_next;
  logic [7:0] shifted_address_next;
  logic [7:0] register_byte_next;
  logic       busy_flag_next;
  logic       has_result;
  logic       burst_go;
  logic       burst_last;
  logic [4:0] lim;
  logic [4:0] pos_inc;
  res_t       step_res;
  res_t       burst_res;

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_code   <= cmd_code_t'(in_command);
      byte_index <= in_byte_index;
      data_byte  <= in_data_byte;
      ack_status <= in_ack_status;
      length     <= in_length;
      slave_addr <= in_slave_addr;
      reg_addr   <= in_reg_addr;
    end
  end

  assign pos_inc = position + 5'd1;
  assign lim     = (int'(position) < MAX_REPORT) ? position : 5'(MAX_REPORT);

  // Store read address for the next step
  always_comb begin
    if (cmd.rd_burst) begin
      rd_addr = {1'b0, bidx};
    end else if (phase == PH_DATA) begin
      rd_addr = pos_inc;
    end else if (phase == PH_STOP) begin
      rd_addr = 5'd0;
    end else begin
      rd_addr = position;
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_addr)] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_ok   <= int'(rd_addr) < BUF_DEPTH;
      rd_data <= mem[AW'(rd_addr)];
    end
  end

  assign store_val = rd_ok ? rd_data : 8'h00;

  // Store writes: transmit load or received byte
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = position;
    wr_data = data_byte;
    if (cmd.step) begin
      if (cmd_code == CMD_LOAD) begin
        wr_addr = {1'b0, byte_index};
        wr_en   = int'(byte_index) < BUF_DEPTH;
      end else if (cmd_code == CMD_EVENT && phase == PH_RESP) begin
        wr_en = int'(position) < BUF_DEPTH;
      end
    end
  end

  // One item applied to the transaction state
  always_comb begin
    phase_next           = phase;
    direction_next       = direction;
    count_target_next    = count_target;
    position_next        = position;
    shifted_address_next = shifted_address;
    register_byte_next   = register_byte;
    busy_flag_next       = busy_flag;
    burst_go             = 1'b0;
    step_res             = '0;
    step_res.last        = 1'b1;
    has_result           = 1'b0;
    case (cmd_code)
      CMD_LOAD: begin
      end
      CMD_WRITE, CMD_READ: begin
        direction_next = (cmd_code == CMD_WRITE) ? DIR_WRITE : DIR_READ;
        if (cmd_code == CMD_READ) begin
          busy_flag_next     = 1'b1;
          register_byte_next = reg_addr;
        end
        count_target_next    = length;
        position_next        = 5'd0;
        shifted_address_next = {slave_addr, 1'b0};
        phase_next           = PH_START;
        has_result           = 1'b1;
        step_res.action      = ACT_START;
      end
      default: begin
        case (phase)
          PH_START: begin
            has_result       = 1'b1;
            step_res.action  = ACT_SEND;
            step_res.tx_byte = shifted_address;
            phase_next       = PH_WADDR;
          end
          PH_WADDR: begin
            if (!ack_status) begin
              if (direction == DIR_WRITE) begin
                has_result       = 1'b1;
                step_res.action  = ACT_SEND;
                step_res.tx_byte = store_val;
              end else if (direction == DIR_READ) begin
                has_result       = 1'b1;
                step_res.action  = ACT_SEND;
                step_res.tx_byte = register_byte;
              end
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            if (!ack_status) begin
              if (direction == DIR_WRITE) begin
                position_next = pos_inc;
                has_result    = 1'b1;
                if (pos_inc < count_target) begin
                  step_res.action  = ACT_SEND;
                  step_res.tx_byte = store_val;
                end else begin
                  step_res.action = ACT_STOP;
                  phase_next      = PH_STOP;
                end
              end else if (direction == DIR_READ) begin
                has_result      = 1'b1;
                step_res.action = ACT_RESTART;
                phase_next      = PH_RESTART;
              end
            end
          end
          PH_RESTART: begin
            has_result       = 1'b1;
            step_res.action  = ACT_SEND;
            step_res.tx_byte = shifted_address | ADDR_READ_BIT;
            phase_next       = PH_RADDR;
          end
          PH_RADDR: begin
            if (!ack_status) begin
              has_result      = 1'b1;
              step_res.action = ACT_RECEIVE;
              phase_next      = PH_RESP;
            end
          end
          PH_RESP: begin
            position_next   = pos_inc;
            has_result      = 1'b1;
            step_res.action = ACT_ACK;
            if (pos_inc < count_target) begin
              phase_next = PH_ACK;
            end else begin
              step_res.ack_bit = 1'b1;
              phase_next       = PH_NACK;
            end
          end
          PH_ACK: begin
            has_result      = 1'b1;
            step_res.action = ACT_RECEIVE;
            phase_next      = PH_RESP;
          end
          PH_NACK: begin
            has_result      = 1'b1;
            step_res.action = ACT_STOP;
            phase_next      = PH_STOP;
          end
          PH_STOP: begin
            if (direction == DIR_WRITE) begin
              has_result      = 1'b1;
              step_res.report = REP_SENT;
            end else if (direction == DIR_READ) begin
              // first receive-complete result; the rest follow as a burst
              has_result        = (lim != 5'd0);
              burst_go          = (lim > 5'd1);
              step_res.report   = REP_RECEIVED;
              step_res.rx_byte  = store_val;
              step_res.rx_count = position;
              step_res.last     = (lim == 5'd1);
            end
            busy_flag_next = 1'b0;
            direction_next = DIR_IDLE;
            phase_next     = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
    endcase
    step_res.busy = busy_flag_next;
  end

  assign burst_last = ({1'b0, bidx} == blim - 5'd1);

  // Status to the controller
  assign sts = '{has_result: has_result, burst_go: burst_go, burst_last: burst_last};

  // Later receive-complete results
  always_comb begin
    burst_res          = '0;
    burst_res.report   = REP_RECEIVED;
    burst_res.rx_byte  = store_val;
    burst_res.rx_count = bcnt;
    burst_res.busy     = busy_flag;
    burst_res.last     = burst_last;
  end

  // Transaction registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      direction       <= DIR_IDLE;
      count_target    <= '0;
      position        <= '0;
      shifted_address <= '0;
      register_byte   <= '0;
      busy_flag       <= 1'b0;
      bidx            <= '0;
      blim            <= '0;
      bcnt            <= '0;
    end else begin
      if (cmd.step) begin
        phase           <= phase_next;
        direction       <= direction_next;
        count_target    <= count_target_next;
        position        <= position_next;
        shifted_address <= shifted_address_next;
        register_byte   <= register_byte_next;
        busy_flag       <= busy_flag_next;
        if (burst_go) begin
          bidx <= 4'd1;
          blim <= lim;
          bcnt <= position;
        end
      end else if (cmd.bstep) begin
        bidx <= bidx + 4'd1;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res <= cmd.bstep ? burst_res : step_res;
    end
  end

endmodule

/* hw/rtl/i2c_master_transaction_sequencer.sv */
// Byte-level I2C master sequencer. Each input transfer is one command: load a
// transmit byte into the store, start a write, start a read, or report that
// the previous bus action finished (with the received byte and the slave ACK).
// The block answers with the next bus action to perform. Items pass through
// capture, store read and update; a new command is taken after the update.
// With one store read port, each of the up to 16 receive-complete results of a
// read needs a store read. Results wait in an output register, so the next
// command is accepted while a result is still pending. A slave NACK where an
// acknowledge is checked yields no result and leaves the transaction where it
// is; a new start replaces any transaction in progress. The byte store is not
// cleared at reset: entries never written read back as unknown data.
module i2c_master_transaction_sequencer #(
  parameter int BUF_DEPTH = i2cseq_pkg::BUF_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_index[3:0], data_byte[11:4], ack_status[12], length[17:13],
  // slave_addr[24:18], reg_addr[32:25], zero fill[39:33]
  input  logic [39:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_byte[7:0], ack_bit[8], rx_byte[16:9], rx_count[21:17], busy_res[22],
  // zero fill[23]
  output logic [23:0] m_axis_tdata,
  // bus_action[2:0], report[4:3]
  output logic [4:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import i2cseq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res;

  i2cseq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  i2cseq_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_command    (s_axis_tuser),
    .in_byte_index (s_axis_tdata[3:0]),
    .in_data_byte  (s_axis_tdata[11:4]),
    .in_ack_status (s_axis_tdata[12]),
    .in_length     (s_axis_tdata[17:13]),
    .in_slave_addr (s_axis_tdata[24:18]),
    .in_reg_addr   (s_axis_tdata[32:25]),
    .res           (res)
  );

  // Result packing
  assign m_axis_tdata = {1'b0, res.busy, res.rx_count, res.rx_byte, res.ack_bit, res.tx_byte};
  assign m_axis_tuser = {res.report, res.action};
  assign m_axis_tlast = res.last;

endmodule
